>>> hdl/periodic_job_dispatcher_unit_defines.svh
// assertion macros for the periodic job dispatcher
`ifndef PERIODIC_JOB_DISPATCHER_UNIT_DEFINES_SVH
`define PERIODIC_JOB_DISPATCHER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PJD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PJD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pjd_pkg.sv
// types and constants shared by the periodic job dispatcher
package pjd_pkg;

  localparam int ID_W  = 8;
  localparam int MS_W  = 32;
  localparam int CMD_W = 2;
  localparam int ST_W  = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SERVICE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PAUSE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESUME  = 2'd3;

  // status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_NOMATCH = 2'd3;

  // period written into a paused job
  localparam logic [MS_W-1:0] PAUSE_PERIOD = 32'd4294967294;

  // one queued job
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [MS_W-1:0] period;
    logic [MS_W-1:0] dflt;
    logic [MS_W-1:0] last_run;
  } job_t;

  // per-cell operation for one execute cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_TAIL,
    OP_LOAD,
    OP_PAUSE,
    OP_RESUME
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     occupied;
  } cell_ctrl_t;

endpackage

>>> hdl/pjd_if.sv
// command and result channel interfaces of the periodic job dispatcher
interface pjd_in_if import pjd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [MS_W-1:0]  now_ms;
  logic [ID_W-1:0]  job_id;
  logic [MS_W-1:0]  period_ms;

  modport source (output valid, command, now_ms, job_id, period_ms, input ready);
  modport sink   (input valid, command, now_ms, job_id, period_ms, output ready);
endinterface

interface pjd_out_if import pjd_pkg::*;;
  logic            valid;
  logic            ready;
  logic            fire;
  logic [ID_W-1:0] fired_job;
  logic [ST_W-1:0] status;

  modport source (output valid, fire, fired_job, status, input ready);
  modport sink   (input valid, fire, fired_job, status, output ready);
endinterface

>>> hdl/pjd_cell.sv
// one queue cell: holds a job, shifts toward the head, matches by id
module pjd_cell import pjd_pkg::*; (
  input  logic            clk,
  input  cell_ctrl_t      ctrl,
  input  job_t            nbr_job,
  input  job_t            head_job,
  input  job_t            new_job,
  input  logic [ID_W-1:0] key_id,
  output job_t            job,
  output logic            match
);

  job_t job_r;
  job_t job_nxt;

  // id match, only for cells that hold a job
  assign match = ctrl.occupied && (job_r.id == key_id);
  assign job   = job_r;

  // next contents of the cell
  always_comb begin
    job_nxt = job_r;
    unique case (ctrl.op)
      OP_HOLD:   job_nxt = job_r;
      OP_SHIFT:  job_nxt = nbr_job;
      OP_TAIL:   job_nxt = head_job;
      OP_LOAD:   job_nxt = new_job;
      OP_PAUSE: begin
        if (match) job_nxt.period = PAUSE_PERIOD;
      end
      OP_RESUME: begin
        if (match) job_nxt.period = job_r.dflt;
      end
      default:   job_nxt = job_r;
    endcase
  end

  // job payload, no reset
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

endmodule

>>> hdl/periodic_job_dispatcher_unit.sv
// periodic job dispatcher: round-robin queue of periodic jobs as a chain of cells
//
// Commands arrive as words on the in_ch channel (valid/ready): add a job, service
// the head job, pause or resume by id. Each command gives exactly one result word
// on out_ch: fire, fired_job (zero when nothing fires) and a status code.
// The queue is a row of MAX_JOBS cells with the head in cell 0. Servicing shifts
// every cell one place toward the head and drops the old head into the tail
// cell, or out of the queue when its period is zero; pause and resume match the
// id in all cells at once. A command is first captured into the command
// registers, then executed from them once the output register is free, and the
// result word is registered in the output register. A new command is not
// accepted before the last one has executed; busy_r holds in_ch.ready low.
// A result waiting in the output register does not block capture of the next
// command; execution of that command waits until the result has been taken.
// Reset (rst_n low, synchronous) empties the queue and clears both channels;
// cell contents are left as they are and are never read while unoccupied.
module periodic_job_dispatcher_unit import pjd_pkg::*; #(
  parameter int MAX_JOBS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  pjd_in_if.sink    in_ch,
  pjd_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  // control state
  logic             busy_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;

  // captured command
  logic [CMD_W-1:0] cmd_r;
  logic [MS_W-1:0]  now_r;
  logic [ID_W-1:0]  id_r;
  logic [MS_W-1:0]  per_r;

  // result word
  logic             fire_r;
  logic [ID_W-1:0]  fired_r;
  logic [ST_W-1:0]  status_r;
  logic             fire_nxt;
  logic [ID_W-1:0]  fired_nxt;
  logic [ST_W-1:0]  status_nxt;

  logic in_go;
  logic exec_go;
  logic q_full;
  logic q_empty;
  logic run_once;
  logic due;
  logic hit;

  job_t                head;
  job_t                head_upd;
  job_t                new_job;
  job_t                cell_job  [MAX_JOBS];
  cell_ctrl_t          cell_ctrl [MAX_JOBS];
  logic [MAX_JOBS-1:0] match_vec;

  // handshake
  assign in_ch.ready = !busy_r;
  assign in_go       = in_ch.valid && !busy_r;
  assign exec_go     = busy_r && (!out_valid_r || out_ch.ready);

  assign q_full  = (count_r == CNT_W'(MAX_JOBS));
  assign q_empty = (count_r == '0);

  // head job decisions
  assign head     = cell_job[0];
  assign run_once = (head.period == '0);
  assign due      = head.period < (now_r - head.last_run);
  assign hit      = |match_vec;

  always_comb begin
    head_upd = head;
    if (due) head_upd.last_run = now_r;
  end

  // new job for an add, due once now_ms passes the time of the add
  always_comb begin
    new_job.id       = id_r;
    new_job.period   = per_r;
    new_job.dflt     = per_r;
    new_job.last_run = now_r - per_r;
  end

  // per-cell operation
  always_comb begin
    for (int i = 0; i < MAX_JOBS; i++) begin
      cell_ctrl[i].occupied = CNT_W'(i) < count_r;
      cell_ctrl[i].op       = OP_HOLD;
      if (exec_go) begin
        unique case (cmd_r)
          CMD_ADD: begin
            if (!q_full && (count_r == CNT_W'(i))) cell_ctrl[i].op = OP_LOAD;
          end
          CMD_SERVICE: begin
            if (!q_empty) begin
              if (!run_once && (CNT_W'(i) == count_r - CNT_W'(1))) cell_ctrl[i].op = OP_TAIL;
              else cell_ctrl[i].op = OP_SHIFT;
            end
          end
          CMD_PAUSE: begin
            if (!q_empty) cell_ctrl[i].op = OP_PAUSE;
          end
          CMD_RESUME: begin
            if (!q_empty) cell_ctrl[i].op = OP_RESUME;
          end
          default: cell_ctrl[i].op = OP_HOLD;
        endcase
      end
    end
  end

  // row of cells, each fed by its neighbour toward the tail, the last by the updated head
  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
    job_t nbr;
    if (g == MAX_JOBS - 1) begin : g_last
      assign nbr = head_upd;
    end else begin : g_mid
      assign nbr = cell_job[g+1];
    end
    pjd_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl[g]),
      .nbr_job  (nbr),
      .head_job (head_upd),
      .new_job  (new_job),
      .key_id   (id_r),
      .job      (cell_job[g]),
      .match    (match_vec[g])
    );
  end

  // result and job count
  always_comb begin
    fire_nxt   = 1'b0;
    fired_nxt  = '0;
    status_nxt = ST_OK;
    count_nxt  = count_r;
    if (cmd_r == CMD_ADD) begin
      if (q_full) status_nxt = ST_FULL;
      else count_nxt = count_r + CNT_W'(1);
    end else if (q_empty) begin
      status_nxt = ST_EMPTY;
    end else if (cmd_r == CMD_SERVICE) begin
      fire_nxt = run_once || due;
      if (run_once || due) fired_nxt = head.id;
      if (run_once) count_nxt = count_r - CNT_W'(1);
    end else begin
      if (!hit) status_nxt = ST_NOMATCH;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_go) busy_r <= 1'b1;
      else if (exec_go) busy_r <= 1'b0;
      if (exec_go) count_r <= count_nxt;
      if (exec_go) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // command capture and result register
  always_ff @(posedge clk) begin
    if (in_go) begin
      cmd_r <= in_ch.command;
      now_r <= in_ch.now_ms;
      id_r  <= in_ch.job_id;
      per_r <= in_ch.period_ms;
    end
    if (exec_go) begin
      fire_r   <= fire_nxt;
      fired_r  <= fired_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.fire      = fire_r;
  assign out_ch.fired_job = fired_r;
  assign out_ch.status    = status_r;

  // checks
  `include "periodic_job_dispatcher_unit_defines.svh"

  `PJD_ASSERT_NOW(a_count_max, 1'b1, count_r <= CNT_W'(MAX_JOBS), "job count above capacity")
  `PJD_ASSERT_NEXT(a_accept_busy, in_go, busy_r, "accepted word not held for execute")
  `PJD_ASSERT_NOW(a_idle_id, out_valid_r && !fire_r, fired_r == '0, "id shown without fire")
  `PJD_ASSERT_NEXT(a_count_hold, !exec_go, $stable(count_r), "job count moved outside execute")

endmodule
